@@ rtl/bounded_stack_with_search_macros.svh @@
// Assertion macros shared by the checker of the bounded stack.
`ifndef BOUNDED_STACK_WITH_SEARCH_MACROS_SVH
`define BOUNDED_STACK_WITH_SEARCH_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define BSS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define BSS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/bss_pkg.sv @@
// Package with the types, codes and sizes of the bounded stack.
package bss_pkg;

    // Number of stack entries.
    localparam int DEPTH = 8;

    // Width of the entry count, which must hold DEPTH itself.
    localparam int CNT_W = $clog2(DEPTH + 1);
    // Width of the scan step counter.
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    // Width of a step plus a count, used for the position arithmetic.
    localparam int SUM_W = CNT_W + 1;
    // Width of the position field of a result beat.
    localparam int POS_W = 4;
    // Width wide enough for any position source before masking.
    localparam int WIDE_W = (SUM_W > POS_W) ? SUM_W : POS_W;

    // Operation codes.
    localparam logic [1:0] OP_PUSH   = 2'd0;
    localparam logic [1:0] OP_POP    = 2'd1;
    localparam logic [1:0] OP_DUMP   = 2'd2;
    localparam logic [1:0] OP_SEARCH = 2'd3;

    // Result status codes.
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_FULL     = 3'd1;
    localparam logic [2:0] ST_EMPTY    = 3'd2;
    localparam logic [2:0] ST_FOUND    = 3'd3;
    localparam logic [2:0] ST_NOTFOUND = 3'd4;

    // One command beat.
    typedef struct packed {
        logic [1:0]         op;
        logic signed [31:0] value;
    } cmd_t;

    // One response beat.
    typedef struct packed {
        logic [2:0]         status;
        logic signed [31:0] data;
        logic [POS_W-1:0]   position;
        logic               last;
    } rsp_t;

    // Shift controls that every cell of the chain sees.
    typedef struct packed {
        logic take_prev;
        logic take_next;
    } cell_ctl_t;

    // Masks a widened count or index down to the position field.
    function automatic logic [POS_W-1:0] to_pos(input logic [WIDE_W-1:0] v);
        return v[POS_W-1:0];
    endfunction

endpackage

@@ rtl/bss_cell.sv @@
// One storage cell of the stack chain; it loads from either neighbor.
module bss_cell (
    input  logic                    clk,
    input  bss_pkg::cell_ctl_t      ctl,
    input  logic signed [31:0]      prev_data,
    input  logic signed [31:0]      next_data,
    output logic signed [31:0]      entry
);

    logic signed [31:0] entry_reg;
    logic signed [31:0] entry_next;

    // Push and rotate move words away from the top; pop moves them toward it.
    always_comb
    begin
        entry_next = entry_reg;
        if (ctl.take_prev)
        begin
            entry_next = prev_data;
        end
        else if (ctl.take_next)
        begin
            entry_next = next_data;
        end
    end

    // The stored word needs no reset: it is read only after a push wrote it.
    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

@@ rtl/bounded_stack_with_search.sv @@
// Top level of the bounded stack: the chain of cells and its sequencer.
//
// Commands arrive on cmd (cmd_valid / cmd_stall), one beat per operation:
// push, pop, dump all or search for a key. Results leave on rsp
// (rsp_valid / rsp_stall); the final result beat of each command has last set.
// The words live in a chain of cells with the top of the stack in cell 0.
// Push and pop shift the whole chain by one place; the
// result appears in the output register on the cycle after the command beat.
// Dump and search rotate the whole chain through the bottom cell, one cell per
// cycle while the output register is not stalled; search then adds a closing
// step that sends its last match or a not-found beat.
// A new command is taken once the previous one has loaded its
// last beat and the output register is free or being emptied.
// Search holds each match back one step so the last one can be marked.
// When the receiver stalls, the output register holds its beat and the
// rotation pauses; the chain always returns to its original order.
// Reset empties the stack and drops any beat in flight; no clearing pass.
module bounded_stack_with_search (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cmd_valid,
    output logic            cmd_stall,
    input  bss_pkg::cmd_t   cmd,
    output logic            rsp_valid,
    input  logic            rsp_stall,
    output bss_pkg::rsp_t   rsp
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FINISH
    } state_t;

    state_t                         state_reg, state_next;
    logic [bss_pkg::CNT_W-1:0]      cnt_reg, cnt_next;
    logic [bss_pkg::IDX_W-1:0]      step_reg, step_next;
    logic                           dump_reg, dump_next;
    logic signed [31:0]             key_reg, key_next;
    logic                           pend_valid_reg, pend_valid_next;
    bss_pkg::rsp_t                  pend_reg, pend_next;
    logic                           rsp_valid_reg, rsp_valid_next;
    bss_pkg::rsp_t                  rsp_reg, rsp_next;

    bss_pkg::cell_ctl_t             cell_ctl;
    logic signed [31:0]             head_in;
    logic signed [31:0]             ent [bss_pkg::DEPTH];
    logic signed [31:0]             bottom;
    logic                           out_free;
    logic                           is_full;
    logic                           is_empty;
    logic [bss_pkg::SUM_W-1:0]      scan_sum;
    logic                           scan_hit;
    logic                           scan_end;
    logic [bss_pkg::POS_W-1:0]      scan_pos;

    // Chain of cells; cell 0 is the top of the stack.
    for (genvar i = 0; i < bss_pkg::DEPTH; i++)
    begin : g_cell
        logic signed [31:0] prev_w;
        logic signed [31:0] next_w;

        if (i == 0)
        begin : g_head
            assign prev_w = head_in;
        end
        else
        begin : g_body
            assign prev_w = ent[i-1];
        end

        if (i == bss_pkg::DEPTH - 1)
        begin : g_tail
            assign next_w = ent[i];
        end
        else
        begin : g_mid
            assign next_w = ent[i+1];
        end

        bss_cell u_cell (
            .clk       (clk),
            .ctl       (cell_ctl),
            .prev_data (prev_w),
            .next_data (next_w),
            .entry     (ent[i])
        );
    end

    assign bottom   = ent[bss_pkg::DEPTH-1];
    assign out_free = !rsp_valid_reg || !rsp_stall;
    assign is_full  = (cnt_reg == bss_pkg::CNT_W'(bss_pkg::DEPTH));
    assign is_empty = (cnt_reg == '0);

    // The bottom cell holds stored word number step + count - DEPTH.
    assign scan_sum = bss_pkg::SUM_W'(step_reg) + bss_pkg::SUM_W'(cnt_reg);
    assign scan_hit = (scan_sum >= bss_pkg::SUM_W'(bss_pkg::DEPTH));
    assign scan_end = (step_reg == bss_pkg::IDX_W'(bss_pkg::DEPTH - 1));
    assign scan_pos = bss_pkg::to_pos(bss_pkg::WIDE_W'(
                          scan_sum - bss_pkg::SUM_W'(bss_pkg::DEPTH)));

    // Sequencer next-state logic.
    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        step_next       = step_reg;
        dump_next       = dump_reg;
        key_next        = key_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        rsp_valid_next  = rsp_valid_reg;
        rsp_next        = rsp_reg;
        cell_ctl        = '0;
        head_in         = bottom;

        if (out_free)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid && out_free)
                begin
                    rsp_valid_next = 1'b1;
                    case (cmd.op)
                        bss_pkg::OP_PUSH:
                        begin
                            if (is_full)
                            begin
                                rsp_next = '{bss_pkg::ST_FULL, 32'sd0,
                                    bss_pkg::to_pos(bss_pkg::WIDE_W'(cnt_reg)), 1'b1};
                            end
                            else
                            begin
                                cell_ctl.take_prev = 1'b1;
                                head_in            = cmd.value;
                                cnt_next           = cnt_reg + bss_pkg::CNT_W'(1);
                                rsp_next = '{bss_pkg::ST_OK, cmd.value,
                                    bss_pkg::to_pos(bss_pkg::WIDE_W'(cnt_next)), 1'b1};
                            end
                        end
                        bss_pkg::OP_POP:
                        begin
                            if (is_empty)
                            begin
                                rsp_next = '{bss_pkg::ST_EMPTY, 32'sd0, '0, 1'b1};
                            end
                            else
                            begin
                                cell_ctl.take_next = 1'b1;
                                cnt_next           = cnt_reg - bss_pkg::CNT_W'(1);
                                rsp_next = '{bss_pkg::ST_OK, ent[0],
                                    bss_pkg::to_pos(bss_pkg::WIDE_W'(cnt_next)), 1'b1};
                            end
                        end
                        bss_pkg::OP_DUMP:
                        begin
                            if (is_empty)
                            begin
                                rsp_next = '{bss_pkg::ST_EMPTY, 32'sd0, '0, 1'b1};
                            end
                            else
                            begin
                                rsp_valid_next = 1'b0;
                                state_next     = S_SCAN;
                                step_next      = '0;
                                dump_next      = 1'b1;
                            end
                        end
                        default:
                        begin
                            if (is_empty)
                            begin
                                rsp_next = '{bss_pkg::ST_NOTFOUND, 32'sd0, '0, 1'b1};
                            end
                            else
                            begin
                                rsp_valid_next  = 1'b0;
                                state_next      = S_SCAN;
                                step_next       = '0;
                                dump_next       = 1'b0;
                                key_next        = cmd.value;
                                pend_valid_next = 1'b0;
                            end
                        end
                    endcase
                end
            end

            S_SCAN:
            begin
                if (out_free)
                begin
                    // Rotate the chain one place through the bottom cell.
                    cell_ctl.take_prev = 1'b1;
                    step_next          = step_reg + bss_pkg::IDX_W'(1);
                    if (scan_hit)
                    begin
                        if (dump_reg)
                        begin
                            rsp_valid_next = 1'b1;
                            rsp_next = '{bss_pkg::ST_OK, bottom, scan_pos, scan_end};
                        end
                        else if (bottom == key_reg)
                        begin
                            // Release the previous match; hold this one back.
                            if (pend_valid_reg)
                            begin
                                rsp_valid_next = 1'b1;
                                rsp_next       = pend_reg;
                            end
                            pend_valid_next = 1'b1;
                            pend_next = '{bss_pkg::ST_FOUND, bottom, scan_pos, 1'b0};
                        end
                    end
                    if (scan_end)
                    begin
                        step_next  = '0;
                        state_next = dump_reg ? S_IDLE : S_FINISH;
                    end
                end
            end

            S_FINISH:
            begin
                if (out_free)
                begin
                    rsp_valid_next = 1'b1;
                    if (pend_valid_reg)
                    begin
                        rsp_next      = pend_reg;
                        rsp_next.last = 1'b1;
                    end
                    else
                    begin
                        rsp_next = '{bss_pkg::ST_NOTFOUND, 32'sd0, '0, 1'b1};
                    end
                    pend_valid_next = 1'b0;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            cnt_reg        <= '0;
            step_reg       <= '0;
            dump_reg       <= 1'b0;
            key_reg        <= '0;
            pend_valid_reg <= 1'b0;
            pend_reg       <= '0;
            rsp_valid_reg  <= 1'b0;
            rsp_reg        <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            step_reg       <= step_next;
            dump_reg       <= dump_next;
            key_reg        <= key_next;
            pend_valid_reg <= pend_valid_next;
            pend_reg       <= pend_next;
            rsp_valid_reg  <= rsp_valid_next;
            rsp_reg        <= rsp_next;
        end
    end

    assign cmd_stall = !((state_reg == S_IDLE) && out_free);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

@@ rtl/bss_checker.sv @@
// Port-level checker for the bounded stack, bound to its top level.
`include "bounded_stack_with_search_macros.svh"

module bss_checker (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cmd_valid,
    input  logic            cmd_stall,
    input  bss_pkg::cmd_t   cmd,
    input  logic            rsp_valid,
    input  logic            rsp_stall,
    input  bss_pkg::rsp_t   rsp
);

    logic open_beat;
    logic fail_beat;

    // A waiting beat that is not the last one of its command.
    assign open_beat = rsp_valid && !rsp.last;

    // A waiting beat that reports full, empty or not found.
    assign fail_beat = rsp_valid && (rsp.status inside
                       {bss_pkg::ST_EMPTY, bss_pkg::ST_NOTFOUND, bss_pkg::ST_FULL});

    // A stalled command beat stays put.
    `BSS_ASSERT_NEXT(a_cmd_hold, cmd_valid && cmd_stall, cmd_valid && $stable(cmd), "stalled command changed")

    // A stalled response beat stays put.
    `BSS_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp), "stalled beat changed")

    // While a non-final beat is waiting, the command is still in progress.
    `BSS_ASSERT_NOW(a_busy_mid_item, open_beat && cmd_valid, cmd_stall, "command taken mid item")

    // Empty, not-found and full results are single beats with no word.
    `BSS_ASSERT_NOW(a_fail_beat, fail_beat, rsp.last && (rsp.data == 32'sd0), "failure beat not bare")

endmodule

bind bounded_stack_with_search bss_checker u_bss_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
);
